>>> rtl/ecfb_pkg.sv
// Shared widths, token type and register map of the eddy-current filter bank.
package ecfb_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DG_W     = SAMPLE_W + 1;
	localparam int COEF_W   = 16;
	localparam int CUR_W    = 24;
	localparam int PROD_W   = CUR_W + COEF_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int COMP_MAX = 4;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	// Register indexes (byte address = 4 * index).
	localparam logic [2:0] REG_AMP_ZERO    = 3'd0;
	localparam logic [2:0] REG_AMP_ONE     = 3'd1;
	localparam logic [2:0] REG_AMP_TWO     = 3'd2;
	localparam logic [2:0] REG_AMP_THREE   = 3'd3;
	localparam logic [2:0] REG_DECAY_ZERO  = 3'd4;
	localparam logic [2:0] REG_DECAY_ONE   = 3'd5;
	localparam logic [2:0] REG_DECAY_TWO   = 3'd6;
	localparam logic [2:0] REG_DECAY_THREE = 3'd7;

	localparam logic signed [CUR_W-1:0] CUR_MAX = {1'b0, {(CUR_W-1){1'b1}}};
	localparam logic signed [CUR_W-1:0] CUR_MIN = {1'b1, {(CUR_W-1){1'b0}}};

	// Data that travels from one cell to the next along with a sample.
	typedef struct packed {
		logic                       restart;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [DG_W-1:0]     dg;
		logic signed [SUM_W-1:0]    sum;
		logic signed [PROD_W-1:0]   prod;
		logic                       sat;
	} ecfb_tok_t;

endpackage

>>> rtl/eddy_current_filter_bank_core.sv
// Eddy-current filter bank: sample in, distorted gradient out, one APB register bank.
// One sample at a time runs down a chain of COMPONENTS cells, through stage one and
// stage two of each, after a load stage that registers the sample and before an
// output register that holds the rounded result. The next sample can be taken in
// the cycle its predecessor's result is transferred, and not earlier. Amplitudes
// and decays sit at byte addresses 0x00..0x1C; the user must write them only while
// the block is idle, which the block itself does not enforce. A restart flag zeroes
// the previous sample and all currents before its sample.
module eddy_current_filter_bank_core import ecfb_pkg::*; #(
	parameter int COMPONENTS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       restart,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] predicted,
	output logic                       saturated
);

	logic signed [COEF_W-1:0]   amp_q   [COMP_MAX];
	logic        [COEF_W-1:0]   decay_q [COMP_MAX];
	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       busy_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] predicted_q;
	logic                       saturated_q;

	logic                       in_xfer;
	logic                       out_xfer;
	logic                       cfg_wr;
	logic [2:0]                 cfg_idx;

	logic                       vld_chain [COMPONENTS+1];
	ecfb_tok_t                  tok_chain [COMPONENTS+1];
	logic                       vld_s0;
	ecfb_tok_t                  tok_s0;
	ecfb_tok_t                  tok_nx0;

	logic signed [SUM_W-1:0]    sum_all;
	logic signed [SUM_W+1:0]    p_raw;
	logic signed [SUM_W-21:0]   p_shr;
	logic signed [SAMPLE_W-1:0] p_sat;
	logic                       p_clip;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign cfg_idx  = paddr[4:2];
	assign out_xfer = out_valid_q & out_ready;
	assign in_ready = ~busy_q | out_xfer;
	assign in_xfer  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMP_MAX; i++) begin
				amp_q[i]   <= '0;
				decay_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_AMP_ZERO:    amp_q[0]   <= pwdata[COEF_W-1:0];
				REG_AMP_ONE:     amp_q[1]   <= pwdata[COEF_W-1:0];
				REG_AMP_TWO:     amp_q[2]   <= pwdata[COEF_W-1:0];
				REG_AMP_THREE:   amp_q[3]   <= pwdata[COEF_W-1:0];
				REG_DECAY_ZERO:  decay_q[0] <= pwdata[COEF_W-1:0];
				REG_DECAY_ONE:   decay_q[1] <= pwdata[COEF_W-1:0];
				REG_DECAY_TWO:   decay_q[2] <= pwdata[COEF_W-1:0];
				REG_DECAY_THREE: decay_q[3] <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_AMP_ZERO:    prdata = {{(DATA_W-COEF_W){1'b0}}, amp_q[0]};
			REG_AMP_ONE:     prdata = {{(DATA_W-COEF_W){1'b0}}, amp_q[1]};
			REG_AMP_TWO:     prdata = {{(DATA_W-COEF_W){1'b0}}, amp_q[2]};
			REG_AMP_THREE:   prdata = {{(DATA_W-COEF_W){1'b0}}, amp_q[3]};
			REG_DECAY_ZERO:  prdata = {{(DATA_W-COEF_W){1'b0}}, decay_q[0]};
			REG_DECAY_ONE:   prdata = {{(DATA_W-COEF_W){1'b0}}, decay_q[1]};
			REG_DECAY_TWO:   prdata = {{(DATA_W-COEF_W){1'b0}}, decay_q[2]};
			REG_DECAY_THREE: prdata = {{(DATA_W-COEF_W){1'b0}}, decay_q[3]};
			default:         prdata = '0;
		endcase
	end

	// Load stage: form the change from the previous sample and launch the token.
	always_comb begin
		tok_nx0.restart = restart;
		tok_nx0.sample  = sample;
		tok_nx0.dg      = DG_W'(sample) - (restart ? DG_W'(0) : DG_W'(prev_q));
		tok_nx0.sum     = '0;
		tok_nx0.prod    = '0;
		tok_nx0.sat     = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			busy_q <= 1'b0;
			prev_q <= '0;
		end else begin
			vld_s0 <= in_xfer;
			if (in_xfer) begin
				busy_q <= 1'b1;
				prev_q <= sample;
			end else if (out_xfer) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tok_s0 <= tok_nx0;
		end
	end

	assign vld_chain[0] = vld_s0;
	assign tok_chain[0] = tok_s0;

	for (genvar g = 0; g < COMPONENTS; g++) begin : g_cell
		ecfb_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.amplitude (amp_q[g]),
			.decay     (decay_q[g]),
			.in_vld    (vld_chain[g]),
			.in_tok    (tok_chain[g]),
			.out_vld   (vld_chain[g+1]),
			.out_tok   (tok_chain[g+1])
		);
	end

	// Output stage: add the last weighted current, subtract from the scaled sample, round and clip.
	always_comb begin
		sum_all = tok_chain[COMPONENTS].sum + SUM_W'(tok_chain[COMPONENTS].prod);
		p_raw   = (SUM_W+2)'($signed({tok_chain[COMPONENTS].sample, 22'd0}))
			- (SUM_W+2)'(sum_all) + (SUM_W+2)'(2097152);
		p_shr   = p_raw[SUM_W+1:22];
		p_clip  = 1'b0;
		if (p_shr > (SUM_W-20)'(32767)) begin
			p_sat  = 16'sh7FFF;
			p_clip = 1'b1;
		end else if (p_shr < (SUM_W-20)'(-32768)) begin
			p_sat  = 16'sh8000;
			p_clip = 1'b1;
		end else begin
			p_sat  = p_shr[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (vld_chain[COMPONENTS]) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_chain[COMPONENTS]) begin
			predicted_q <= p_sat;
			saturated_q <= tok_chain[COMPONENTS].sat | p_clip;
		end
	end

	assign out_valid = out_valid_q;
	assign predicted = predicted_q;
	assign saturated = saturated_q;

endmodule

>>> rtl/ecfb_cell.sv
// One eddy-current component: holds its current and updates it in two stages.
module ecfb_cell import ecfb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [COEF_W-1:0] amplitude,
	input  logic        [COEF_W-1:0] decay,
	input  logic                     in_vld,
	input  ecfb_tok_t                in_tok,
	output logic                     out_vld,
	output ecfb_tok_t                out_tok
);

	logic signed [CUR_W-1:0]    cur_q;
	logic                       vld_s1;
	ecfb_tok_t                  tok_s1;
	logic signed [CUR_W-1:0]    cur_s1;
	logic signed [PROD_W:0]     dprod_s1;
	logic                       vld_s2;
	ecfb_tok_t                  tok_s2;

	logic signed [CUR_W-1:0]    cur_eff;
	logic signed [PROD_W+1:0]   drnd;
	logic signed [CUR_W+1:0]    dec;
	logic signed [CUR_W:0]      dg_sh;
	logic signed [CUR_W+2:0]    cur_raw;
	logic signed [CUR_W-1:0]    cur_new;
	logic                       cur_clip;
	ecfb_tok_t                  tok_nx1;
	ecfb_tok_t                  tok_nx2;

	assign cur_eff = in_tok.restart ? '0 : cur_q;

	always_comb begin
		tok_nx1     = in_tok;
		tok_nx1.sum = in_tok.sum + SUM_W'(in_tok.prod);
	end

	// Stage one: decay product, and fold in the previous cell's weighted current.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			tok_s1   <= tok_nx1;
			cur_s1   <= cur_eff;
			dprod_s1 <= (PROD_W+1)'(cur_eff) * (PROD_W+1)'($signed({1'b0, decay}));
		end
	end

	// Stage two: round the decay term, update and clip the current, weight it.
	always_comb begin
		drnd     = (PROD_W+2)'(dprod_s1) + (PROD_W+2)'(32768);
		dec      = drnd[PROD_W+1:16];
		dg_sh    = {tok_s1.dg, 8'd0};
		cur_raw  = (CUR_W+3)'(cur_s1) + (CUR_W+3)'(dg_sh) - (CUR_W+3)'(dec);
		cur_clip = 1'b0;
		if (cur_raw > (CUR_W+3)'(CUR_MAX)) begin
			cur_new  = CUR_MAX;
			cur_clip = 1'b1;
		end else if (cur_raw < (CUR_W+3)'(CUR_MIN)) begin
			cur_new  = CUR_MIN;
			cur_clip = 1'b1;
		end else begin
			cur_new  = cur_raw[CUR_W-1:0];
		end
		tok_nx2      = tok_s1;
		tok_nx2.prod = PROD_W'(cur_new) * PROD_W'(amplitude);
		tok_nx2.sat  = tok_s1.sat | cur_clip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			cur_q  <= '0;
		end else begin
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				cur_q <= cur_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			tok_s2 <= tok_nx2;
		end
	end

	assign out_vld = vld_s2;
	assign out_tok = tok_s2;

endmodule

>>> rtl/ecfb_checker.sv
// Port-level checks of the filter bank's one-item-at-a-time flow, bound to the top level.
module ecfb_checker import ecfb_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [SAMPLE_W-1:0] predicted,
	input logic                       saturated
);

	// A transfer in starts a new item, so no result can be shown in the next cycle.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result shown right after an input transfer");

	// Only one item is in flight after a transfer in.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready while an item is in flight");

	// A waiting result blocks new input.
	a_blocked_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input ready while a result waits");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(predicted) && $stable(saturated))
		else $error("stalled result changed");

endmodule

bind eddy_current_filter_bank_core ecfb_checker u_ecfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.predicted (predicted),
	.saturated (saturated)
);
